>>> rtl/stepper_move_block_planner_core_macros.svh
// Assertion macros for the planner RTL.
`ifndef STEPPER_MOVE_BLOCK_PLANNER_CORE_MACROS_SVH
`define STEPPER_MOVE_BLOCK_PLANNER_CORE_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define SMBP_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("planner check failed");
// Next-cycle implication, checked outside reset.
`define SMBP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("planner check failed");
`endif

>>> rtl/smbp_pkg.sv
// Shared types and constants of the stepper move planner.
package smbp_pkg;
   localparam int unsigned COORD_W     = 32;
   localparam int unsigned FEED_W      = 24;
   localparam int unsigned SPM_W       = 32;
   localparam int unsigned MAG_W       = 33;
   localparam int unsigned ADDR_W      = 3;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [SPM_W-1:0] SPM_RESET    = 32'd65536;
   localparam logic [14:0]      TICK_SCALE   = 15'd25000;
   localparam logic [31:0]      MIN_INTERVAL = 32'd2;

   typedef enum logic {
      REG_X_SPM = 1'b0,
      REG_Y_SPM = 1'b1
   } reg_index_type;

   // one planned move handed from front to back
   typedef struct packed {
      logic              moved;
      logic [31:0]       steps_x;
      logic [31:0]       steps_y;
      logic [MAG_W-1:0]  mag_x;
      logic [MAG_W-1:0]  mag_y;
      logic [FEED_W-1:0] feed;
      logic [31:0]       step_count;
   } plan_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;
endpackage

>>> rtl/smbp_if.sv
// Valid/ready channel interfaces for move requests and planned moves.
interface smbp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] target_x;
   logic [31:0] target_y;
   logic [23:0] feed_speed;
   modport source(output valid, target_x, target_y, feed_speed, input ready);
   modport sink(input valid, target_x, target_y, feed_speed, output ready);
endinterface

interface smbp_rsp_if;
   logic        valid;
   logic        ready;
   logic        moved;
   logic [31:0] steps_x;
   logic [31:0] steps_y;
   logic        dir_x;
   logic        dir_y;
   logic [31:0] step_count;
   logic [31:0] step_interval;
   modport source(output valid, moved, steps_x, steps_y, dir_x, dir_y, step_count,
                  step_interval, input ready);
   modport sink(input valid, moved, steps_x, steps_y, dir_x, dir_y, step_count,
                step_interval, output ready);
endinterface

>>> rtl/smbp_front.sv
// Front: takes targets, scales deltas to steps bit-serially, tracks position.
module smbp_front (
   input  logic                     clock,
   input  logic                     reset,
   smbp_req_if.sink                 req_bus,
   input  logic [31:0]              spm_x,
   input  logic [31:0]              spm_y,
   input  smbp_pkg::queue_status_type q_status,
   output logic                     plan_push,
   output smbp_pkg::plan_type       plan_data
);
   typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_type;

   fstate_type        state_ff, state_in;
   logic [31:0]       pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [31:0]       tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [23:0]       feed_ff, feed_in;
   logic [32:0]       mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic              neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [31:0]       sh_x_ff, sh_x_in, sh_y_ff, sh_y_in;
   logic [64:0]       pr_x_ff, pr_x_in, pr_y_ff, pr_y_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [32:0]       diff_x, diff_y;
   logic [33:0]       add_x, add_y;
   logic [64:0]       rnd_x, rnd_y;
   logic [31:0]       st_x, st_y, abs_x, abs_y, pmax;
   logic              moved;

   function automatic logic [31:0] sat_steps(input logic [38:0] s, input logic neg);
      logic [31:0] r;
      if (neg) begin
         r = (s > 39'h0080000000) ? 32'h80000000 : (~s[31:0] + 32'd1);
      end else begin
         r = (s > 39'h007FFFFFFF) ? 32'h7FFFFFFF : s[31:0];
      end
      return r;
   endfunction

   assign req_bus.ready = (state_ff == F_IDLE);
   assign diff_x = {req_bus.target_x[31], req_bus.target_x} - {pos_x_ff[31], pos_x_ff};
   assign diff_y = {req_bus.target_y[31], req_bus.target_y} - {pos_y_ff[31], pos_y_ff};

   // shift-add: add the multiplicand into the top half, then shift right
   assign add_x = {1'b0, pr_x_ff[64:32]} + (sh_x_ff[0] ? {1'b0, mag_x_ff} : 34'd0);
   assign add_y = {1'b0, pr_y_ff[64:32]} + (sh_y_ff[0] ? {1'b0, mag_y_ff} : 34'd0);

   // round half away from zero on magnitude, then saturate signed
   assign rnd_x = pr_x_ff + 65'h2000000;
   assign rnd_y = pr_y_ff + 65'h2000000;
   assign st_x  = sat_steps(rnd_x[64:26], neg_x_ff);
   assign st_y  = sat_steps(rnd_y[64:26], neg_y_ff);
   assign abs_x = st_x[31] ? (~st_x + 32'd1) : st_x;
   assign abs_y = st_y[31] ? (~st_y + 32'd1) : st_y;
   assign pmax  = (abs_x > abs_y) ? abs_x : abs_y;
   assign moved = (st_x != 32'd0) || (st_y != 32'd0);

   assign plan_push = (state_ff == F_PUSH) && !q_status.full;
   always_comb begin
      plan_data.moved      = moved;
      plan_data.steps_x    = st_x;
      plan_data.steps_y    = st_y;
      plan_data.mag_x      = mag_x_ff;
      plan_data.mag_y      = mag_y_ff;
      plan_data.feed       = feed_ff;
      plan_data.step_count = (pmax == 32'd0) ? 32'd1 : pmax;
   end

   always_comb begin
      state_in = state_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      tgt_x_in = tgt_x_ff;
      tgt_y_in = tgt_y_ff;
      feed_in  = feed_ff;
      mag_x_in = mag_x_ff;
      mag_y_in = mag_y_ff;
      neg_x_in = neg_x_ff;
      neg_y_in = neg_y_ff;
      sh_x_in  = sh_x_ff;
      sh_y_in  = sh_y_ff;
      pr_x_in  = pr_x_ff;
      pr_y_in  = pr_y_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_bus.valid) begin
               tgt_x_in = req_bus.target_x;
               tgt_y_in = req_bus.target_y;
               feed_in  = req_bus.feed_speed;
               neg_x_in = diff_x[32];
               neg_y_in = diff_y[32];
               mag_x_in = diff_x[32] ? (~diff_x + 33'd1) : diff_x;
               mag_y_in = diff_y[32] ? (~diff_y + 33'd1) : diff_y;
               sh_x_in  = spm_x;
               sh_y_in  = spm_y;
               pr_x_in  = '0;
               pr_y_in  = '0;
               cnt_in   = '0;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            pr_x_in = {add_x, pr_x_ff[31:1]};
            pr_y_in = {add_y, pr_y_ff[31:1]};
            sh_x_in = {1'b0, sh_x_ff[31:1]};
            sh_y_in = {1'b0, sh_y_ff[31:1]};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_status.full) begin
               if (moved) begin
                  pos_x_in = tgt_x_ff;
                  pos_y_in = tgt_y_ff;
               end
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
      tgt_x_ff <= tgt_x_in;
      tgt_y_ff <= tgt_y_in;
      feed_ff  <= feed_in;
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      sh_x_ff  <= sh_x_in;
      sh_y_ff  <= sh_y_in;
      pr_x_ff  <= pr_x_in;
      pr_y_ff  <= pr_y_in;
      cnt_ff   <= cnt_in;
   end
endmodule

>>> rtl/smbp_queue.sv
// Small FIFO of planned moves between front and back.
module smbp_queue #(
   parameter int unsigned DEPTH = smbp_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  smbp_pkg::plan_type          push_data,
   input  logic                        pop,
   output smbp_pkg::plan_type          pop_data,
   output smbp_pkg::queue_status_type  status
);
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   smbp_pkg::plan_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

>>> rtl/smbp_back.sv
// Back: path length by serial square and root, step interval by serial divide.
module smbp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  smbp_pkg::queue_status_type  q_status,
   input  smbp_pkg::plan_type          plan_data,
   output logic                        plan_pop,
   smbp_rsp_if.source                  rsp_bus
);
   typedef enum logic [2:0] {
      B_IDLE, B_SQUARE, B_SUM, B_ROOT, B_SCALE, B_DIVIDE, B_DONE
   } bstate_type;

   bstate_type         state_ff, state_in;
   smbp_pkg::plan_type plan_ff, plan_in;
   logic [32:0]        mx_sh_ff, mx_sh_in, my_sh_ff, my_sh_in;
   logic [65:0]        sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic [65:0]        rad_ff, rad_in;
   logic [36:0]        rem_ff, rem_in;
   logic [32:0]        root_ff, root_in;
   logic [47:0]        quo_ff, quo_in;
   logic [55:0]        den_ff, den_in;
   logic [56:0]        drem_ff, drem_in;
   logic [31:0]        ivl_ff, ivl_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               valid_ff, valid_in;
   logic               moved_ff, moved_in;
   logic [31:0]        sx_ff, sx_in, sy_ff, sy_in, ps_ff, ps_in, it_ff, it_in;
   logic [33:0]        add_x, add_y;
   logic [36:0]        rem_sh, trial;
   logic [56:0]        dtry;
   logic               dge;
   logic [31:0]        q_sat;

   assign add_x = {1'b0, sq_x_ff[65:33]} + (mx_sh_ff[0] ? {1'b0, plan_ff.mag_x} : 34'd0);
   assign add_y = {1'b0, sq_y_ff[65:33]} + (my_sh_ff[0] ? {1'b0, plan_ff.mag_y} : 34'd0);
   assign rem_sh = {rem_ff[34:0], rad_ff[65:64]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign dtry   = {drem_ff[55:0], quo_ff[47]};
   assign dge    = (dtry >= {1'b0, den_ff});
   assign q_sat  = (quo_ff[47:32] != 16'd0) ? 32'hFFFFFFFF : quo_ff[31:0];

   assign plan_pop = (state_ff == B_IDLE) && !q_status.empty;

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.moved         = moved_ff;
   assign rsp_bus.steps_x       = sx_ff;
   assign rsp_bus.steps_y       = sy_ff;
   assign rsp_bus.dir_x         = moved_ff && !sx_ff[31];
   assign rsp_bus.dir_y         = moved_ff && !sy_ff[31];
   assign rsp_bus.step_count    = ps_ff;
   assign rsp_bus.step_interval = it_ff;

   always_comb begin
      state_in = state_ff;
      plan_in  = plan_ff;
      mx_sh_in = mx_sh_ff;
      my_sh_in = my_sh_ff;
      sq_x_in  = sq_x_ff;
      sq_y_in  = sq_y_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      drem_in  = drem_ff;
      ivl_in   = ivl_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      moved_in = moved_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      ps_in    = ps_ff;
      it_in    = it_ff;
      if (valid_ff && rsp_bus.ready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               plan_in  = plan_data;
               mx_sh_in = plan_data.mag_x;
               my_sh_in = plan_data.mag_y;
               sq_x_in  = '0;
               sq_y_in  = '0;
               cnt_in   = '0;
               state_in = plan_data.moved ? B_SQUARE : B_DONE;
            end
         end
         B_SQUARE: begin
            sq_x_in  = {add_x, sq_x_ff[32:1]};
            sq_y_in  = {add_y, sq_y_ff[32:1]};
            mx_sh_in = {1'b0, mx_sh_ff[32:1]};
            my_sh_in = {1'b0, my_sh_ff[32:1]};
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) begin
               state_in = B_SUM;
            end
         end
         B_SUM: begin
            rad_in   = sq_x_ff + sq_y_ff;
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = B_ROOT;
         end
         B_ROOT: begin
            // one root bit per cycle, two radicand bits consumed
            rad_in = {rad_ff[63:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[31:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[31:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) begin
               state_in = B_SCALE;
            end
         end
         B_SCALE: begin
            quo_in  = 48'(root_ff) * 48'(smbp_pkg::TICK_SCALE);
            den_in  = 56'(plan_ff.feed) * 56'(plan_ff.step_count);
            drem_in = '0;
            cnt_in  = '0;
            if (plan_ff.feed == '0) begin
               ivl_in   = 32'hFFFFFFFF;
               state_in = B_DONE;
            end else begin
               state_in = B_DIVIDE;
            end
         end
         B_DIVIDE: begin
            drem_in = dge ? (dtry - {1'b0, den_ff}) : dtry;
            quo_in  = {quo_ff[46:0], dge};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (q_sat < smbp_pkg::MIN_INTERVAL) begin
               it_in = smbp_pkg::MIN_INTERVAL;
            end else begin
               it_in = q_sat;
            end
            if (!valid_ff || rsp_bus.ready) begin
               valid_in = 1'b1;
               moved_in = plan_ff.moved;
               if (plan_ff.moved) begin
                  sx_in = plan_ff.steps_x;
                  sy_in = plan_ff.steps_y;
                  ps_in = plan_ff.step_count;
                  if (plan_ff.feed == '0) begin
                     it_in = ivl_ff;
                  end
               end else begin
                  sx_in = '0;
                  sy_in = '0;
                  ps_in = '0;
                  it_in = '0;
               end
               state_in = B_IDLE;
            end else begin
               it_in = it_ff;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      plan_ff  <= plan_in;
      mx_sh_ff <= mx_sh_in;
      my_sh_ff <= my_sh_in;
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      drem_ff  <= drem_in;
      ivl_ff   <= ivl_in;
      cnt_ff   <= cnt_in;
      moved_ff <= moved_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      ps_ff    <= ps_in;
      it_ff    <= it_in;
   end
endmodule

>>> rtl/stepper_move_block_planner_core.sv
// Top level of the two-axis constant-velocity stepper move planner.
// Each request transaction carries a target X/Y (1/1024 mm) and a feedrate
// (1/256 mm/s); each produces exactly one response transaction with the signed
// step deltas, direction bits, path step count and the step timer interval for
// a 100 kHz timer. The front takes a request and scales both axis deltas by the
// steps-per-mm registers with a bit-serial multiplier, then updates the tracked
// position. Planned moves queue up to QUEUE_DEPTH deep; the back squares both
// deltas serially, takes a bit-serial square root and a restoring divide, and
// handles one move at a time; a no-move request skips these steps.
// Responses sit in an output register, so the back keeps working while a
// result waits. Steps-per-mm registers lie at byte addresses 0 (X) and 4 (Y)
// and must only be written while the planner is idle.
`include "stepper_move_block_planner_core_macros.svh"
module stepper_move_block_planner_core #(
   parameter int unsigned QUEUE_DEPTH = smbp_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   smbp_req_if.sink                      req_bus,
   smbp_rsp_if.source                    rsp_bus,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [smbp_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   logic [31:0]                 spm_x_ff, spm_x_in, spm_y_ff, spm_y_in;
   logic                        csr_wr;
   logic                        plan_push, plan_pop;
   smbp_pkg::plan_type          push_data, pop_data;
   smbp_pkg::queue_status_type  q_status;

   // APB: zero wait states; register index is the word address bit
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (smbp_pkg::reg_index_type'(csr_paddr[2]) == smbp_pkg::REG_Y_SPM)
                       ? spm_y_ff : spm_x_ff;

   always_comb begin
      spm_x_in = spm_x_ff;
      spm_y_in = spm_y_ff;
      if (csr_wr) begin
         case (smbp_pkg::reg_index_type'(csr_paddr[2]))
            smbp_pkg::REG_X_SPM: spm_x_in = csr_pwdata;
            smbp_pkg::REG_Y_SPM: spm_y_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spm_x_ff <= smbp_pkg::SPM_RESET;
         spm_y_ff <= smbp_pkg::SPM_RESET;
      end else begin
         spm_x_ff <= spm_x_in;
         spm_y_ff <= spm_y_in;
      end
   end

   smbp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .spm_x     (spm_x_ff),
      .spm_y     (spm_y_ff),
      .q_status  (q_status),
      .plan_push (plan_push),
      .plan_data (push_data)
   );

   smbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (plan_push),
      .push_data (push_data),
      .pop       (plan_pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   smbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .plan_data (pop_data),
      .plan_pop  (plan_pop),
      .rsp_bus   (rsp_bus)
   );

   // front never pushes into a full queue, back never pops an empty one
   `SMBP_ASSERT_NOW(a_push_not_full, plan_push, !q_status.full)
   `SMBP_ASSERT_NOW(a_pop_not_empty, plan_pop, !q_status.empty)
   // a real move always has a nonzero step count and an interval of at least two
   `SMBP_ASSERT_NOW(a_move_fields, rsp_bus.valid && rsp_bus.moved,
                    rsp_bus.step_count != 32'd0 && rsp_bus.step_interval >= 32'd2)
   // a no-move response carries all zero fields
   `SMBP_ASSERT_NOW(a_nomove_zero, rsp_bus.valid && !rsp_bus.moved,
                    rsp_bus.steps_x == 32'd0 && rsp_bus.steps_y == 32'd0 &&
                    rsp_bus.step_count == 32'd0 && rsp_bus.step_interval == 32'd0)
endmodule

>>> tb/sv/tb_stepper_move_block_planner_core.sv
// Testbench for the stepper move planner: directed and random moves checked against a predictor.
module tb_stepper_move_block_planner_core;

   typedef struct packed {
      logic        moved;
      logic [31:0] steps_x;
      logic [31:0] steps_y;
      logic        dir_x;
      logic        dir_y;
      logic [31:0] step_count;
      logic [31:0] step_interval;
   } move_type;

   // Predicts planned moves and checks response transactions in order.
   class move_scoreboard;
      logic [31:0] spm_x, spm_y;
      logic [31:0] pos_x, pos_y;
      move_type    pending[$];
      int          mismatches;

      function new();
         spm_x = smbp_pkg::SPM_RESET;
         spm_y = smbp_pkg::SPM_RESET;
         pos_x = '0;
         pos_y = '0;
         mismatches = 0;
      endfunction

      function void set_spm(smbp_pkg::reg_index_type idx, logic [31:0] value);
         if (idx == smbp_pkg::REG_X_SPM) spm_x = value;
         else spm_y = value;
      endfunction

      // rounded, saturated step count; returns signed 64-bit
      function longint scale_axis(longint unsigned mag, bit neg, logic [31:0] spm);
         longint unsigned s;
         s = (mag * longint'(spm) + 64'd33554432) >> 26;
         if (neg) return (s > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(s);
         return (s > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(s);
      endfunction

      function void note_request(logic [31:0] tx, logic [31:0] ty, logic [23:0] feed);
         longint dx, dy, sx, sy;
         longint unsigned mx, my, ax, ay, p, len, c;
         logic [127:0] sq, ticks;
         move_type m;
         dx = longint'($signed(tx)) - longint'($signed(pos_x));
         dy = longint'($signed(ty)) - longint'($signed(pos_y));
         mx = dx < 0 ? -dx : dx;
         my = dy < 0 ? -dy : dy;
         sx = scale_axis(mx, dx < 0, spm_x);
         sy = scale_axis(my, dy < 0, spm_y);
         m = '{default: '0};
         if (sx != 0 || sy != 0) begin
            ax = sx < 0 ? -sx : sx;
            ay = sy < 0 ? -sy : sy;
            p = ax > ay ? ax : ay;
            if (p == 0) p = 1;
            sq = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
            len = 0;
            for (int b = 34; b >= 0; b--) begin
               c = len | (64'd1 << b);
               if (128'(c) * 128'(c) <= sq) len = c;
            end
            if (feed == 0) ticks = 128'hFFFF_FFFF;
            else begin
               ticks = (128'(smbp_pkg::TICK_SCALE) * 128'(len)) / (128'(feed) * 128'(p));
               if (ticks > 128'hFFFF_FFFF) ticks = 128'hFFFF_FFFF;
            end
            if (ticks < 128'(smbp_pkg::MIN_INTERVAL)) ticks = 128'(smbp_pkg::MIN_INTERVAL);
            m.moved = 1'b1;
            m.steps_x = sx[31:0];
            m.steps_y = sy[31:0];
            m.dir_x = sx >= 0;
            m.dir_y = sy >= 0;
            m.step_count = p[31:0];
            m.step_interval = ticks[31:0];
            pos_x = tx;
            pos_y = ty;
         end
         pending.push_back(m);
      endfunction

      function void check_response(move_type got);
         move_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transaction");
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %0b %0d %0d %0b %0b %0d %0d got %0b %0d %0d %0b %0b %0d %0d",
                        e.moved, $signed(e.steps_x), $signed(e.steps_y), e.dir_x, e.dir_y,
                        e.step_count, e.step_interval, got.moved, $signed(got.steps_x),
                        $signed(got.steps_y), got.dir_x, got.dir_y, got.step_count,
                        got.step_interval);
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 400;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [smbp_pkg::ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   int cycles;

   smbp_req_if req_bus();
   smbp_rsp_if rsp_bus();
   move_scoreboard planner_sb;

   stepper_move_block_planner_core i_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // cycle watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side: sample at the rising edge, random backpressure at the falling edge
   initial begin
      int stall;
      move_type got;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         repeat (stall) @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && !reset));
         got.moved = rsp_bus.moved;
         got.steps_x = rsp_bus.steps_x;
         got.steps_y = rsp_bus.steps_y;
         got.dir_x = rsp_bus.dir_x;
         got.dir_y = rsp_bus.dir_y;
         got.step_count = rsp_bus.step_count;
         got.step_interval = rsp_bus.step_interval;
         planner_sb.check_response(got);
         @(negedge clock);
         rsp_bus.ready <= 1'b0;
      end
   end

   // APB write: setup cycle then access cycle
   task automatic write_spm(smbp_pkg::reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= smbp_pkg::ADDR_W'(4 * int'(idx));
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      planner_sb.set_spm(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // one request transaction, with an optional random gap before it
   task automatic send_move(logic [31:0] tx, logic [31:0] ty, logic [23:0] feed, bit gap);
      @(negedge clock);
      if (gap && $urandom_range(0, 3) != 0) repeat ($urandom_range(0, 19)) @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.target_x <= tx;
      req_bus.target_y <= ty;
      req_bus.feed_speed <= feed;
      do @(posedge clock); while (!req_bus.ready);
      planner_sb.note_request(tx, ty, feed);
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // every response back, then let the back end settle before a register write
   task automatic drain();
      while (planner_sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 200000)) - 100000);
         default: return 32'($signed($urandom_range(0, 4000)) - 2000);
      endcase
   endfunction

   function automatic logic [31:0] rand_spm();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom();
         default: return $urandom_range(1 << 14, 200 << 16);
      endcase
   endfunction

   initial begin
      logic [31:0] spm_x_set[5] = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd5242880, 32'd1};
      logic [31:0] spm_y_set[5] = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd2621440, 32'd1};
      logic [23:0] feed;
      planner_sb = new();
      cycles = 0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.target_x = '0;
      req_bus.target_y = '0;
      req_bus.feed_speed = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, no move, zero feed, floor and saturation of the interval
      send_move(32'd0, 32'd0, 24'd1000, 1'b0);               // no move
      send_move(32'd1024, 32'd0, 24'd0, 1'b0);               // zero feedrate
      send_move(32'd1024, 32'd1024, 24'hFF_FFFF, 1'b0);      // interval floor
      send_move(32'h7FFF_FFFF, 32'h8000_0000, 24'd1, 1'b1);  // extreme targets
      send_move(32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, 1'b1);
      send_move(32'h8000_0000, 32'h7FFF_FFFF, 24'd5, 1'b1);  // no move again
      send_move(32'h8000_0100, 32'h7FFF_FFFF, 24'd1, 1'b1);
      send_move(32'h8000_0100, 32'h7FFF_FE00, 24'd256, 1'b1);
      send_move(32'h0000_0200, 32'h0000_0000, 24'd256, 1'b0); // back near the origin before a half-step move
      send_move(32'h0000_0000, 32'h0000_0000, 24'd256, 1'b0);
      drain();

      // settings sweep, extremes among them; later ones random
      for (int phase = 0; phase < 10; phase++) begin
         write_spm(smbp_pkg::REG_X_SPM, phase < 5 ? spm_x_set[phase] : rand_spm());
         write_spm(smbp_pkg::REG_Y_SPM, phase < 5 ? spm_y_set[phase] : rand_spm());
         if (phase == 4) begin
            // one step at a time with unit scale: tiny deltas round to zero or one
            send_move(planner_sb.pos_x, planner_sb.pos_y, 24'd9, 1'b0);
            send_move(32'd32768, 32'd0, 24'd9, 1'b0);
            send_move(32'd32767, 32'd0, 24'd9, 1'b0);
         end
         for (int n = 0; n < 80; n++) begin
            int mode;
            mode = $urandom_range(0, 2);
            case ($urandom_range(0, 5))
               0: feed = 24'd0;
               1: feed = 24'hFF_FFFF;
               2: feed = 24'($urandom());
               default: feed = 24'($urandom_range(1, 20000));
            endcase
            if ($urandom_range(0, 9) == 0)
               send_move(planner_sb.pos_x, planner_sb.pos_y, feed, 1'b1);
            else
               send_move(rand_coord(mode), rand_coord(mode), feed, 1'b1);
            // hold off until the planner has caught up
            if (n == 40)
               while (planner_sb.pending.size() != 0) @(negedge clock);
         end
         drain();
      end

      if (planner_sb.mismatches == 0 && planner_sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
